[src/cau_pkg.sv]
// cau_pkg: shared types, constants and helpers for the complex arithmetic unit.
// No dependencies; used by every module in src/.
package cau_pkg;

    // Fixed-point format and CORDIC length
    localparam int FRAC_BITS    = 24;
    localparam int CORDIC_STEPS = 24;   // 8..32

    // Divider: quotient bits kept below the overflow check
    localparam int QBITS   = 33;
    localparam int DIV_LAT = QBITS + 1;
    localparam int PIPE_LAT = 2 + DIV_LAT + 1;

    // CORDIC datapath width, gain compensation (Q30)
    localparam int CW = 36;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam int COR_PAD = DIV_LAT - CORDIC_STEPS - 1;

    // Arctangent table in turn units (2^32 = one turn)
    localparam logic [31:0] ATAN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_NEG   = 4'd4,
        OP_CONJ  = 4'd5,
        OP_SDIV  = 4'd6,
        OP_MOD   = 4'd7,
        OP_ARG   = 4'd8,
        OP_POLAR = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DZ     = 2'd1,
        ST_NEGMOD = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    // Per-item data that bypasses the divider and CORDIC
    typedef struct packed {
        t_op                op;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               sat;
        t_status            err;
        logic               flip;
        logic               zarg;
    } t_side;

    // Divider operands for both lanes
    typedef struct packed {
        logic        neg_re;
        logic        neg_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic [63:0] den;
    } t_div_in;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [QBITS-1:0] quo;
    } t_div_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        logic                 rot;
    } t_cor;

    typedef struct packed {
        logic [33:0]          mag;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
    } t_cor_out;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] v;
    } t_clamp;

    // Clamp a wide signed value into the 32-bit signed range
    function automatic t_clamp sat32(input logic signed [65:0] v);
        t_clamp r;
        r.sat = 1'b0;
        r.v   = v[31:0];
        if (v > 66'sd2147483647) begin
            r.sat = 1'b1;
            r.v   = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r.sat = 1'b1;
            r.v   = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

[src/complex_arith_unit_top.sv]
// complex_arith_unit_top: complex ALU with CORDIC, fully pipelined.
// Depends on cau_pkg, cau_front, cau_div_lane, cau_cordic, cau_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  in       | i_valid / o_ready  | i_op, i_a_re, i_a_im, i_b_re, i_b_im,
//           |                    | i_divisor, i_polar_mod, i_polar_angle
//  out      | o_valid / i_ready  | o_res_re, o_res_im, o_res_magnitude,
//           |                    | o_res_angle, o_status
//
// One item per cycle through PIPE_LAT = 37 register stages: two input stages,
// overflow check plus 33 quotient stages, and the output register. CORDIC
// (CORDIC_STEPS stages plus gain) runs beside the divider and is padded to the
// same length. Reset clears only the valid bits. While a result waits in the
// output register and i_ready is low, the whole pipeline holds.
module complex_arith_unit_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [3:0]           i_op,
    input  logic signed [31:0]   i_a_re,
    input  logic signed [31:0]   i_a_im,
    input  logic signed [31:0]   i_b_re,
    input  logic signed [31:0]   i_b_im,
    input  logic signed [31:0]   i_divisor,
    input  logic signed [31:0]   i_polar_mod,
    input  logic [31:0]          i_polar_angle,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_res_re,
    output logic signed [31:0]   o_res_im,
    output logic [30:0]          o_res_magnitude,
    output logic [31:0]          o_res_angle,
    output logic [1:0]           o_status
);

    localparam int LAT = cau_pkg::PIPE_LAT;

    logic                 en;
    logic [LAT-1:0]       r_vld;
    cau_pkg::t_side       w_side;
    cau_pkg::t_div_in     w_div;
    cau_pkg::t_cor        w_cor;
    cau_pkg::t_div_out    w_q_re, w_q_im;
    cau_pkg::t_cor_out    w_cres;
    cau_pkg::t_side       r_side_dl [cau_pkg::DIV_LAT];

    // Global advance: pipeline moves unless a result is held
    assign en      = ~o_valid | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    // Valid bits, one per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    cau_front u_front (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_op          (i_op),
        .i_a_re        (i_a_re),
        .i_a_im        (i_a_im),
        .i_b_re        (i_b_re),
        .i_b_im        (i_b_im),
        .i_divisor     (i_divisor),
        .i_polar_mod   (i_polar_mod),
        .i_polar_angle (i_polar_angle),
        .o_side        (w_side),
        .o_div         (w_div),
        .o_cor         (w_cor)
    );

    cau_div_lane u_div_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (w_div.neg_re),
        .i_mag (w_div.mag_re),
        .i_den (w_div.den),
        .o_res (w_q_re)
    );

    cau_div_lane u_div_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (w_div.neg_im),
        .i_mag (w_div.mag_im),
        .i_den (w_div.den),
        .o_res (w_q_im)
    );

    cau_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cor (w_cor),
        .o_res (w_cres)
    );

    // Side data rides alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_dl[0] <= w_side;
            for (int k = 1; k < cau_pkg::DIV_LAT; k++) r_side_dl[k] <= r_side_dl[k-1];
        end
    end

    cau_back u_back (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_side          (r_side_dl[cau_pkg::DIV_LAT-1]),
        .i_div_re        (w_q_re),
        .i_div_im        (w_q_im),
        .i_cor           (w_cres),
        .o_res_re        (o_res_re),
        .o_res_im        (o_res_im),
        .o_res_magnitude (o_res_magnitude),
        .o_res_angle     (o_res_angle),
        .o_status        (o_status)
    );

    // An empty output stage never blocks intake
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");

    // An accepted item occupies the first stage next cycle
    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item lost at first stage");

    // Divide by zero reports zero in every result field
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cau_pkg::ST_DZ) |->
        (o_res_re == 32'sd0 && o_res_im == 32'sd0 && o_res_magnitude == 31'd0
         && o_res_angle == 32'd0))
        else $error("divide by zero with nonzero result");

endmodule

[src/cau_front.sv]
// cau_front: two input stages - products, then sums, simple ops and operand setup.
// Depends on cau_pkg.
module cau_front (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0]           i_op,
    input  logic signed [31:0]   i_a_re,
    input  logic signed [31:0]   i_a_im,
    input  logic signed [31:0]   i_b_re,
    input  logic signed [31:0]   i_b_im,
    input  logic signed [31:0]   i_divisor,
    input  logic signed [31:0]   i_polar_mod,
    input  logic [31:0]          i_polar_angle,
    output cau_pkg::t_side       o_side,
    output cau_pkg::t_div_in     o_div,
    output cau_pkg::t_cor        o_cor
);

    // Stage 1 registers
    cau_pkg::t_op        r1_op;
    logic signed [31:0]  r1_ar, r1_ai, r1_br, r1_bi, r1_dv;
    logic [31:0]         r1_pa;
    logic signed [63:0]  r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bb, r1_p_cc;
    logic [30:0]         r1_px;
    cau_pkg::t_status    r1_err;

    cau_pkg::t_status    n1_err;
    logic [60:0]         n1_pxw;

    // Error detection on raw operands
    always_comb begin
        n1_err = cau_pkg::ST_OK;
        case (cau_pkg::t_op'(i_op))
            cau_pkg::OP_DIV: begin
                if (i_b_re == 32'sd0 && i_b_im == 32'sd0) n1_err = cau_pkg::ST_DZ;
            end
            cau_pkg::OP_SDIV: begin
                if (i_divisor == 32'sd0) n1_err = cau_pkg::ST_DZ;
            end
            cau_pkg::OP_POLAR: begin
                if (i_polar_mod[31]) n1_err = cau_pkg::ST_NEGMOD;
            end
            default: n1_err = cau_pkg::ST_OK;
        endcase
        n1_pxw = 61'(i_polar_mod[30:0]) * 61'(cau_pkg::GAIN_Q30);
    end

    // Stage 1: multipliers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op   <= cau_pkg::t_op'(i_op);
            r1_ar   <= i_a_re;
            r1_ai   <= i_a_im;
            r1_br   <= i_b_re;
            r1_bi   <= i_b_im;
            r1_dv   <= i_divisor;
            r1_pa   <= i_polar_angle;
            r1_p_rr <= i_a_re * i_b_re;
            r1_p_ii <= i_a_im * i_b_im;
            r1_p_ri <= i_a_re * i_b_im;
            r1_p_ir <= i_a_im * i_b_re;
            r1_p_bb <= i_b_re * i_b_re;
            r1_p_cc <= i_b_im * i_b_im;
            r1_px   <= n1_pxw[60:30];
            r1_err  <= n1_err;
        end
    end

    // Stage 2 combinational work
    logic signed [65:0]  s_ar, s_ai, s_br, s_bi;
    logic signed [64:0]  m_re, m_im, d_re, d_im;
    logic [31:0]         abs_ar, abs_ai, abs_dv;
    cau_pkg::t_clamp     f_re, f_im;
    cau_pkg::t_side      n_side;
    cau_pkg::t_div_in    n_div;
    cau_pkg::t_cor       n_cor;
    logic signed [31:0]  pa_s;

    always_comb begin
        s_ar   = {{34{r1_ar[31]}}, r1_ar};
        s_ai   = {{34{r1_ai[31]}}, r1_ai};
        s_br   = {{34{r1_br[31]}}, r1_br};
        s_bi   = {{34{r1_bi[31]}}, r1_bi};
        abs_ar = r1_ar[31] ? 32'(-r1_ar) : r1_ar;
        abs_ai = r1_ai[31] ? 32'(-r1_ai) : r1_ai;
        abs_dv = r1_dv[31] ? 32'(-r1_dv) : r1_dv;
        pa_s   = $signed(r1_pa);

        // Multiply sums, rounded toward minus infinity
        m_re = $signed({r1_p_rr[63], r1_p_rr}) - $signed({r1_p_ii[63], r1_p_ii});
        m_im = $signed({r1_p_ri[63], r1_p_ri}) + $signed({r1_p_ir[63], r1_p_ir});
        // Division numerators
        d_re = $signed({r1_p_rr[63], r1_p_rr}) + $signed({r1_p_ii[63], r1_p_ii});
        d_im = $signed({r1_p_ir[63], r1_p_ir}) - $signed({r1_p_ri[63], r1_p_ri});

        n_side      = '0;
        n_side.op   = r1_op;
        n_side.err  = r1_err;
        n_side.zarg = (r1_ar == 32'sd0) && (r1_ai == 32'sd0);

        // Divider operands: complex divide by default, scalar divide on request
        n_div.neg_re = d_re[64];
        n_div.neg_im = d_im[64];
        n_div.mag_re = d_re[64] ? 64'(-d_re) : d_re[63:0];
        n_div.mag_im = d_im[64] ? 64'(-d_im) : d_im[63:0];
        n_div.den    = {1'b0, r1_p_bb[62:0]} + {1'b0, r1_p_cc[62:0]};
        if (r1_op == cau_pkg::OP_SDIV) begin
            n_div.neg_re = r1_ar[31] ^ r1_dv[31];
            n_div.neg_im = r1_ai[31] ^ r1_dv[31];
            n_div.mag_re = {32'd0, abs_ar};
            n_div.mag_im = {32'd0, abs_ai};
            n_div.den    = {32'd0, abs_dv};
        end

        // CORDIC start vector
        n_cor.x   = {{(cau_pkg::CW-32){1'b0}}, abs_ar};
        n_cor.y   = {{(cau_pkg::CW-32){1'b0}}, abs_ai};
        n_cor.z   = 32'd0;
        n_cor.rot = 1'b0;
        case (r1_op)
            cau_pkg::OP_ARG: begin
                if (r1_ar[31]) begin
                    n_cor.x = -$signed({{(cau_pkg::CW-32){r1_ar[31]}}, r1_ar});
                    n_cor.y = -$signed({{(cau_pkg::CW-32){r1_ai[31]}}, r1_ai});
                    n_cor.z = 32'h80000000;
                end else begin
                    n_cor.x = {{(cau_pkg::CW-32){1'b0}}, r1_ar};
                    n_cor.y = {{(cau_pkg::CW-32){r1_ai[31]}}, r1_ai};
                end
            end
            cau_pkg::OP_POLAR: begin
                n_side.flip = (pa_s > 32'sh40000000) || (pa_s < -32'sh40000000);
                n_cor.x   = {{(cau_pkg::CW-31){1'b0}}, r1_px};
                n_cor.y   = '0;
                n_cor.z   = n_side.flip ? (r1_pa ^ 32'h80000000) : r1_pa;
                n_cor.rot = 1'b1;
            end
            default: ;
        endcase

        // Simple ops finish here
        f_re = '0;
        f_im = '0;
        case (r1_op)
            cau_pkg::OP_ADD: begin
                f_re = cau_pkg::sat32(s_ar + s_br);
                f_im = cau_pkg::sat32(s_ai + s_bi);
            end
            cau_pkg::OP_SUB: begin
                f_re = cau_pkg::sat32(s_ar - s_br);
                f_im = cau_pkg::sat32(s_ai - s_bi);
            end
            cau_pkg::OP_MUL: begin
                f_re = cau_pkg::sat32($signed({m_re[64], m_re}) >>> cau_pkg::FRAC_BITS);
                f_im = cau_pkg::sat32($signed({m_im[64], m_im}) >>> cau_pkg::FRAC_BITS);
            end
            cau_pkg::OP_NEG: begin
                f_re = cau_pkg::sat32(-s_ar);
                f_im = cau_pkg::sat32(-s_ai);
            end
            cau_pkg::OP_CONJ: begin
                f_re.sat = 1'b0;
                f_re.v   = r1_ar;
                f_im = cau_pkg::sat32(-s_ai);
            end
            default: ;
        endcase
        n_side.re  = f_re.v;
        n_side.im  = f_im.v;
        n_side.sat = f_re.sat | f_im.sat;
    end

    // Stage 2 registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= n_side;
            o_div  <= n_div;
            o_cor  <= n_cor;
        end
    end

endmodule

[src/cau_div_lane.sv]
// cau_div_lane: pipelined fractional divider, floor(mag * 2^FRAC_BITS / den),
// one quotient bit per stage after an overflow check. Depends on cau_pkg.
module cau_div_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_neg,
    input  logic [63:0]          i_mag,
    input  logic [63:0]          i_den,
    output cau_pkg::t_div_out    o_res
);

    localparam int QB = cau_pkg::QBITS;
    localparam int F  = cau_pkg::FRAC_BITS;

    logic [63:0]   r_rem [QB+1];
    logic [QB-1:0] r_lo  [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic [63:0]   r_den [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];

    // Numerator scaled by 2^F; the part above the low QB bits seeds the remainder
    logic [63+F:0] n_full;
    logic [63:0]   n_init;

    always_comb begin
        n_full = {i_mag, {F{1'b0}}};
        n_init = 64'(n_full[63+F:QB]);
    end

    // Overflow check stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_init;
            r_lo[0]  <= n_full[QB-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= (n_init >= i_den);
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [64:0] trial;
        logic        ge;
        logic [64:0] diff;

        always_comb begin
            trial = {r_rem[j-1], r_lo[j-1][QB-j]};
            ge    = trial >= {1'b0, r_den[j-1]};
            diff  = trial - {1'b0, r_den[j-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? diff[63:0] : trial[63:0];
                r_lo[j]  <= r_lo[j-1];
                r_quo[j] <= {r_quo[j-1][QB-2:0], ge};
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_res.neg = r_neg[QB];
    assign o_res.ovf = r_ovf[QB];
    assign o_res.quo = r_quo[QB];

endmodule

[src/cau_cordic.sv]
// cau_cordic: unrolled CORDIC, vectoring or rotation per item, gain stage and
// alignment delay to the divider latency. Depends on cau_pkg.
module cau_cordic (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  cau_pkg::t_cor        i_cor,
    output cau_pkg::t_cor_out    o_res
);

    localparam int N  = cau_pkg::CORDIC_STEPS;
    localparam int CW = cau_pkg::CW;

    cau_pkg::t_cor     r_st  [N];
    cau_pkg::t_cor     w_pre [N];
    cau_pkg::t_cor_out r_g;
    cau_pkg::t_cor_out r_pad [cau_pkg::COR_PAD];

    assign w_pre[0] = i_cor;
    for (genvar i = 1; i < N; i++) begin : g_link
        assign w_pre[i] = r_st[i-1];
    end

    // Micro-rotation stages
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [CW-1:0] dx, dy;
        logic                 ccw;
        cau_pkg::t_cor        n_st;

        always_comb begin
            dx  = $signed(w_pre[i].y) >>> i;
            dy  = $signed(w_pre[i].x) >>> i;
            // rotation follows the angle sign, vectoring the y sign
            ccw = w_pre[i].rot ? ~w_pre[i].z[31] : w_pre[i].y[CW-1];
            n_st.rot = w_pre[i].rot;
            if (ccw) begin
                n_st.x = w_pre[i].x - dx;
                n_st.y = w_pre[i].y + dy;
                n_st.z = w_pre[i].z - cau_pkg::ATAN[i];
            end else begin
                n_st.x = w_pre[i].x + dx;
                n_st.y = w_pre[i].y - dy;
                n_st.z = w_pre[i].z + cau_pkg::ATAN[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_st[i] <= n_st;
        end
    end

    // Gain compensation for the modulus
    logic [63:0] n_prod;
    always_comb begin
        n_prod = 64'(r_st[N-1].x[33:0]) * 64'(cau_pkg::GAIN_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g.mag <= n_prod[63:30];
            r_g.x   <= r_st[N-1].x;
            r_g.y   <= r_st[N-1].y;
            r_g.z   <= r_st[N-1].z;
        end
    end

    // Alignment delay
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pad[0] <= r_g;
            for (int k = 1; k < cau_pkg::COR_PAD; k++) r_pad[k] <= r_pad[k-1];
        end
    end

    assign o_res = r_pad[cau_pkg::COR_PAD-1];

endmodule

[src/cau_back.sv]
// cau_back: result selection, saturation and status per op, into the output register.
// Depends on cau_pkg.
module cau_back (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  cau_pkg::t_side       i_side,
    input  cau_pkg::t_div_out    i_div_re,
    input  cau_pkg::t_div_out    i_div_im,
    input  cau_pkg::t_cor_out    i_cor,
    output logic signed [31:0]   o_res_re,
    output logic signed [31:0]   o_res_im,
    output logic [30:0]          o_res_magnitude,
    output logic [31:0]          o_res_angle,
    output logic [1:0]           o_status
);

    // Signed quotient with saturation; an overflowed quotient pins to a bound
    function automatic cau_pkg::t_clamp div_fin(input cau_pkg::t_div_out d);
        cau_pkg::t_clamp    r;
        logic signed [65:0] sv;
        sv = d.neg ? -$signed({{(66-cau_pkg::QBITS){1'b0}}, d.quo})
                   :  $signed({{(66-cau_pkg::QBITS){1'b0}}, d.quo});
        r = cau_pkg::sat32(sv);
        if (d.ovf) begin
            r.sat = 1'b1;
            r.v   = d.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return r;
    endfunction

    localparam int CWX = cau_pkg::CW;
    cau_pkg::t_clamp    c_re, c_im;
    logic signed [CWX-1:0] fx, fy;
    logic signed [31:0] n_re, n_im;
    logic [30:0]        n_mag;
    logic [31:0]        n_ang;
    logic               n_sat;
    cau_pkg::t_status   n_st;

    always_comb begin
        c_re  = '0;
        c_im  = '0;
        fx    = i_side.flip ? -i_cor.x : i_cor.x;
        fy    = i_side.flip ? -i_cor.y : i_cor.y;
        n_re  = '0;
        n_im  = '0;
        n_mag = '0;
        n_ang = '0;
        n_sat = 1'b0;
        case (i_side.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL,
            cau_pkg::OP_NEG, cau_pkg::OP_CONJ: begin
                n_re  = i_side.re;
                n_im  = i_side.im;
                n_sat = i_side.sat;
            end
            cau_pkg::OP_DIV, cau_pkg::OP_SDIV: begin
                if (i_side.err == cau_pkg::ST_OK) begin
                    c_re  = div_fin(i_div_re);
                    c_im  = div_fin(i_div_im);
                    n_re  = c_re.v;
                    n_im  = c_im.v;
                    n_sat = c_re.sat | c_im.sat;
                end
            end
            cau_pkg::OP_MOD: begin
                if (i_cor.mag > 34'd2147483647) begin
                    n_mag = 31'h7FFFFFFF;
                    n_sat = 1'b1;
                end else begin
                    n_mag = i_cor.mag[30:0];
                end
            end
            cau_pkg::OP_ARG: begin
                n_ang = i_side.zarg ? 32'd0 : i_cor.z;
            end
            cau_pkg::OP_POLAR: begin
                if (i_side.err == cau_pkg::ST_OK) begin
                    c_re  = cau_pkg::sat32(66'(fx));
                    c_im  = cau_pkg::sat32(66'(fy));
                    n_re  = c_re.v;
                    n_im  = c_im.v;
                    n_sat = c_re.sat | c_im.sat;
                end
            end
            default: ;
        endcase
        if (i_side.err != cau_pkg::ST_OK) n_st = i_side.err;
        else if (n_sat)                   n_st = cau_pkg::ST_SAT;
        else                              n_st = cau_pkg::ST_OK;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_re        <= n_re;
            o_res_im        <= n_im;
            o_res_magnitude <= n_mag;
            o_res_angle     <= n_ang;
            o_status        <= n_st;
        end
    end

endmodule
